### hw/rtl/urb_pkg.sv
// Shared constants, operation codes and the command type for the UART byte queues.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package urb_pkg;

	// Queue depths and derived widths
	localparam int RX_DEPTH  = 256;
	localparam int TX_DEPTH  = 256;
	localparam int RX_PTR_W  = $clog2(RX_DEPTH);
	localparam int RX_CNT_W  = $clog2(RX_DEPTH);
	localparam int TX_PTR_W  = $clog2(TX_DEPTH);
	localparam int TX_CNT_W  = $clog2(TX_DEPTH + 1);
	localparam int BYTE_W    = 8;
	localparam int OP_W      = 2;
	localparam int RX_FILL_W = 8;
	localparam int TX_FILL_W = 9;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [OP_W-1:0]   op_t;

	// Operation codes
	localparam op_t OP_RX_BYTE  = 2'd0;
	localparam op_t OP_TX_EMPTY = 2'd1;
	localparam op_t OP_TX_WRITE = 2'd2;
	localparam op_t OP_GET_CHAR = 2'd3;

	// Classified command handed from the front end to the executor
	typedef struct packed {
		op_t   op;
		logic  rx_drop;   // received byte carries a line error
		logic  txe;       // transmitter empty, transmit writes only
		byte_t data;
	} cmd_t;

endpackage

### hw/rtl/urb_front.sv
// Front end: takes requests, classifies them and holds them in a two-entry queue.
// Depends on urb_pkg.
`timescale 1ns / 1ps

module urb_front
	import urb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  op_t   op,
	input  byte_t data_byte,
	input  logic  line_error,
	input  logic  transmitter_empty,
	output logic  cmd_valid,
	output cmd_t  cmd
);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	cmd_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;
	cmd_t              cls;

	// Classify the incoming request
	always_comb begin
		cls.op      = op;
		cls.rx_drop = (op == OP_RX_BYTE) && line_error;
		cls.txe     = (op == OP_TX_WRITE) && transmitter_empty;
		cls.data    = data_byte;
	end

	assign busy      = (cnt_q == QCNT_W'(QDEPTH));
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid;   // executor never stalls
	assign cmd       = q_mem_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/urb_back.sv
// Executor: owns both byte stores, pointers and counts; runs one command a cycle.
// Depends on urb_pkg; fed by urb_front.
`timescale 1ns / 1ps

module urb_back
	import urb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  cmd_t                 cmd,
	output logic                 done,
	output logic                 send_valid,
	output byte_t                send_byte,
	output logic                 read_valid,
	output byte_t                read_byte,
	output logic                 put_rejected,
	output logic [RX_FILL_W-1:0] rx_fill,
	output logic [TX_FILL_W-1:0] tx_fill,
	output logic                 rx_overflowed,
	output logic                 tx_irq_enabled
);

	// Byte stores
	byte_t rx_mem [RX_DEPTH];
	byte_t tx_mem [TX_DEPTH];
	byte_t rx_rd_q;
	byte_t tx_rd_q;

	// Queue state
	logic [RX_PTR_W-1:0] rx_wptr_q, rx_rptr_q, rx_wptr_d, rx_rptr_d;
	logic [RX_CNT_W-1:0] rx_cnt_q, rx_cnt_d;
	logic [TX_PTR_W-1:0] tx_wptr_q, tx_rptr_q, tx_wptr_d, tx_rptr_d;
	logic [TX_CNT_W-1:0] tx_cnt_q, tx_cnt_d;
	logic                ovf_q, ovf_d;
	logic                irq_q, irq_d;

	// Store strobes and result flags
	logic rx_we, rx_re, tx_we, tx_re;
	logic send_v, send_mem, read_v, rejected;

	// Result stage
	logic  done_s2, send_v_s2, send_mem_s2, read_v_s2, rejected_s2;
	byte_t data_s2;

	// Decide the effect of the command at the head of the queue
	always_comb begin
		rx_wptr_d = rx_wptr_q;
		rx_rptr_d = rx_rptr_q;
		rx_cnt_d  = rx_cnt_q;
		tx_wptr_d = tx_wptr_q;
		tx_rptr_d = tx_rptr_q;
		tx_cnt_d  = tx_cnt_q;
		ovf_d     = ovf_q;
		irq_d     = irq_q;
		rx_we     = 1'b0;
		rx_re     = 1'b0;
		tx_we     = 1'b0;
		tx_re     = 1'b0;
		send_v    = 1'b0;
		send_mem  = 1'b0;
		read_v    = 1'b0;
		rejected  = 1'b0;
		if (cmd_valid) begin
			unique case (cmd.op)
				OP_RX_BYTE: begin
					if (!cmd.rx_drop) begin
						rx_we     = 1'b1;
						rx_wptr_d = (rx_wptr_q == RX_PTR_W'(RX_DEPTH - 1)) ?
							'0 : rx_wptr_q + 1'b1;
						// a full wrap empties the queue and latches overflow
						if (rx_cnt_q == RX_CNT_W'(RX_DEPTH - 1)) begin
							rx_cnt_d = '0;
							ovf_d    = 1'b1;
						end else begin
							rx_cnt_d = rx_cnt_q + 1'b1;
						end
					end
				end
				OP_TX_EMPTY: begin
					if (tx_cnt_q != '0) begin
						tx_re     = 1'b1;
						send_v    = 1'b1;
						send_mem  = 1'b1;
						tx_cnt_d  = tx_cnt_q - 1'b1;
						tx_rptr_d = (tx_rptr_q == TX_PTR_W'(TX_DEPTH - 1)) ?
							'0 : tx_rptr_q + 1'b1;
					end else begin
						irq_d = 1'b0;
					end
				end
				OP_TX_WRITE: begin
					if (tx_cnt_q == TX_CNT_W'(TX_DEPTH)) begin
						rejected = 1'b1;
					end else if ((tx_cnt_q != '0) || !cmd.txe) begin
						tx_we     = 1'b1;
						tx_cnt_d  = tx_cnt_q + 1'b1;
						tx_wptr_d = (tx_wptr_q == TX_PTR_W'(TX_DEPTH - 1)) ?
							'0 : tx_wptr_q + 1'b1;
						irq_d     = 1'b1;
					end else begin
						// idle path: straight to the transmitter
						send_v = 1'b1;
						irq_d  = 1'b0;
					end
				end
				OP_GET_CHAR: begin
					if (rx_cnt_q != '0) begin
						rx_re     = 1'b1;
						read_v    = 1'b1;
						rx_cnt_d  = rx_cnt_q - 1'b1;
						rx_rptr_d = (rx_rptr_q == RX_PTR_W'(RX_DEPTH - 1)) ?
							'0 : rx_rptr_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Receive store, registered read
	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_mem[rx_wptr_q] <= cmd.data;
		end
		if (rx_re) begin
			rx_rd_q <= rx_mem[rx_rptr_q];
		end
	end

	// Transmit store, registered read
	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_wptr_q] <= cmd.data;
		end
		if (tx_re) begin
			tx_rd_q <= tx_mem[tx_rptr_q];
		end
	end

	// Pointers, counts and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wptr_q <= '0;
			rx_rptr_q <= '0;
			rx_cnt_q  <= '0;
			tx_wptr_q <= '0;
			tx_rptr_q <= '0;
			tx_cnt_q  <= '0;
			ovf_q     <= 1'b0;
			irq_q     <= 1'b1;
		end else begin
			rx_wptr_q <= rx_wptr_d;
			rx_rptr_q <= rx_rptr_d;
			rx_cnt_q  <= rx_cnt_d;
			tx_wptr_q <= tx_wptr_d;
			tx_rptr_q <= tx_rptr_d;
			tx_cnt_q  <= tx_cnt_d;
			ovf_q     <= ovf_d;
			irq_q     <= irq_d;
		end
	end

	// Result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2     <= 1'b0;
			send_v_s2   <= 1'b0;
			read_v_s2   <= 1'b0;
			rejected_s2 <= 1'b0;
		end else begin
			done_s2     <= cmd_valid;
			send_v_s2   <= send_v;
			read_v_s2   <= read_v;
			rejected_s2 <= rejected;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		send_mem_s2 <= send_mem;
		data_s2     <= cmd.data;
	end

	// Results; fills and flags are the state after the step
	assign done           = done_s2;
	assign send_valid     = send_v_s2;
	assign send_byte      = !send_v_s2 ? '0 : (send_mem_s2 ? tx_rd_q : data_s2);
	assign read_valid     = read_v_s2;
	assign read_byte      = read_v_s2 ? rx_rd_q : '0;
	assign put_rejected   = rejected_s2;
	assign rx_fill        = RX_FILL_W'(rx_cnt_q);
	assign tx_fill        = TX_FILL_W'(tx_cnt_q);
	assign rx_overflowed  = ovf_q;
	assign tx_irq_enabled = irq_q;

endmodule

### hw/rtl/uart_rx_tx_ring_buffers.sv
// Top level of the UART receive and transmit byte queues.
// Depends on urb_pkg, urb_front and urb_back.
`timescale 1ns / 1ps

// Channel   Handshake        Payload
// request   start / busy     op, data_byte, line_error, transmitter_empty
// result    done (strobe)    send_valid, send_byte, read_valid, read_byte,
//                            put_rejected, rx_fill, tx_fill, rx_overflowed,
//                            tx_irq_enabled
//
// A taken request passes the command queue, then the result stage, to done.
// One request a cycle is sustained: the executor retires one command per cycle,
// limited by the single access to each byte store's port.
// busy stays low in operation: the executor pops the command queue every cycle,
// so the two-entry queue never holds more than one command.
// Reset is immediate; the byte stores need no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle per request.

module uart_rx_tx_ring_buffers
	import urb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  op_t                  op,
	input  byte_t                data_byte,
	input  logic                 line_error,
	input  logic                 transmitter_empty,
	output logic                 done,
	output logic                 send_valid,
	output byte_t                send_byte,
	output logic                 read_valid,
	output byte_t                read_byte,
	output logic                 put_rejected,
	output logic [RX_FILL_W-1:0] rx_fill,
	output logic [TX_FILL_W-1:0] tx_fill,
	output logic                 rx_overflowed,
	output logic                 tx_irq_enabled
);

	logic cmd_valid;
	cmd_t cmd;

	// Front end: accept and classify
	urb_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.op                (op),
		.data_byte         (data_byte),
		.line_error        (line_error),
		.transmitter_empty (transmitter_empty),
		.cmd_valid         (cmd_valid),
		.cmd               (cmd)
	);

	// Back end: execute against the queues
	urb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.done           (done),
		.send_valid     (send_valid),
		.send_byte      (send_byte),
		.read_valid     (read_valid),
		.read_byte      (read_byte),
		.put_rejected   (put_rejected),
		.rx_fill        (rx_fill),
		.tx_fill        (tx_fill),
		.rx_overflowed  (rx_overflowed),
		.tx_irq_enabled (tx_irq_enabled)
	);

`ifndef ASSERT_OFF
	// Every accepted request is answered on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request not answered in two cycles");

	// A rejected put only happens with the transmit queue full
	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && put_rejected) |-> (tx_fill == TX_FILL_W'(TX_DEPTH)))
		else $error("put rejected while transmit queue had room");

	// One operation cannot both send and read a byte
	a_one_path: assert property (@(posedge clk) disable iff (!arst_n)
		!(send_valid && read_valid))
		else $error("send and read in the same result");

	// Queuing a byte for transmit always arms the interrupt
	a_irq_on_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (tx_fill > $past(tx_fill))) |-> tx_irq_enabled)
		else $error("byte queued without transmit interrupt enabled");
`endif

endmodule

### sim/urb_checker.sv
`timescale 1ns / 1ps
// Checker for the UART byte queues: watches the request and result channels,
// keeps its own copy of both queues, predicts each result and compares it.
// Depends on urb_pkg for the depths, widths and operation codes.

module urb_checker
	import urb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  op_t                  op,
	input  byte_t                data_byte,
	input  logic                 line_error,
	input  logic                 transmitter_empty,
	input  logic                 done,
	input  logic                 send_valid,
	input  byte_t                send_byte,
	input  logic                 read_valid,
	input  byte_t                read_byte,
	input  logic                 put_rejected,
	input  logic [RX_FILL_W-1:0] rx_fill,
	input  logic [TX_FILL_W-1:0] tx_fill,
	input  logic                 rx_overflowed,
	input  logic                 tx_irq_enabled,
	output int                   fail_count,
	output int                   pending
);

	// One result, fields in port order
	typedef struct packed {
		logic                 send_valid;
		byte_t                send_byte;
		logic                 read_valid;
		byte_t                read_byte;
		logic                 put_rejected;
		logic [RX_FILL_W-1:0] rx_fill;
		logic [TX_FILL_W-1:0] tx_fill;
		logic                 rx_overflowed;
		logic                 tx_irq_enabled;
	} queue_status_t;

	// Predicted queue state
	byte_t rx_mem [RX_DEPTH];
	byte_t tx_mem [TX_DEPTH];
	int    rx_wr, rx_rd, rx_held;
	int    tx_wr, tx_rd, tx_held;
	logic  overflow_seen;
	logic  irq_enable;

	queue_status_t expected_status [$];
	queue_status_t observed, predicted;
	int            fail_total = 0;
	int            reported   = 0;

	function automatic int next_slot(int p, int depth);
		return (p + 1 >= depth) ? 0 : p + 1;
	endfunction

	// Apply one request to the predicted queues and work out its result
	task automatic predict_status(op_t o, byte_t d, logic err, logic txe,
	                              output queue_status_t r);
		r = '0;
		case (o)
			OP_RX_BYTE: if (!err) begin
				rx_mem[rx_wr] = d;
				rx_wr = next_slot(rx_wr, RX_DEPTH);
				rx_held++;
				// wrap: queue counted as empty again, overflow sticks
				if (rx_held >= RX_DEPTH) begin
					rx_held = 0;
					overflow_seen = 1'b1;
				end
			end
			OP_TX_EMPTY: if (tx_held != 0) begin
				tx_held--;
				r.send_valid = 1'b1;
				r.send_byte = tx_mem[tx_rd];
				tx_rd = next_slot(tx_rd, TX_DEPTH);
			end else begin
				irq_enable = 1'b0;
			end
			OP_TX_WRITE: if (tx_held >= TX_DEPTH) begin
				r.put_rejected = 1'b1;
			end else if (tx_held != 0 || !txe) begin
				tx_mem[tx_wr] = d;
				tx_wr = next_slot(tx_wr, TX_DEPTH);
				tx_held++;
				irq_enable = 1'b1;
			end else begin
				// empty queue and idle transmitter: straight out
				irq_enable = 1'b0;
				r.send_valid = 1'b1;
				r.send_byte = d;
			end
			OP_GET_CHAR: if (rx_held != 0) begin
				r.read_valid = 1'b1;
				r.read_byte = rx_mem[rx_rd];
				rx_rd = next_slot(rx_rd, RX_DEPTH);
				rx_held--;
			end
		endcase
		r.rx_fill        = RX_FILL_W'(rx_held);
		r.tx_fill        = TX_FILL_W'(tx_held);
		r.rx_overflowed  = overflow_seen;
		r.tx_irq_enabled = irq_enable;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wr = 0;
			rx_rd = 0;
			rx_held = 0;
			tx_wr = 0;
			tx_rd = 0;
			tx_held = 0;
			overflow_seen = 1'b0;
			irq_enable = 1'b1;
			expected_status.delete();
			pending <= 0;
			fail_count <= fail_total;
		end else begin
			// result side first: the oldest request's prediction
			if (done) begin
				observed = {send_valid, send_byte, read_valid, read_byte, put_rejected,
				            rx_fill, tx_fill, rx_overflowed, tx_irq_enabled};
				if (expected_status.size() == 0) begin
					fail_total++;
					if (reported < 10) begin
						reported++;
						$display("%0t: result with no request outstanding: %p", $realtime, observed);
					end
				end else begin
					predicted = expected_status.pop_front();
					if (observed !== predicted) begin
						fail_total++;
						if (reported < 10) begin
							reported++;
							$display("%0t: result mismatch", $realtime);
							$display("  expected send %b/%h read %b/%h rej %b rx %0d tx %0d ovf %b irq %b",
							         predicted.send_valid, predicted.send_byte,
							         predicted.read_valid, predicted.read_byte,
							         predicted.put_rejected, predicted.rx_fill,
							         predicted.tx_fill, predicted.rx_overflowed,
							         predicted.tx_irq_enabled);
							$display("  actual   send %b/%h read %b/%h rej %b rx %0d tx %0d ovf %b irq %b",
							         observed.send_valid, observed.send_byte,
							         observed.read_valid, observed.read_byte,
							         observed.put_rejected, observed.rx_fill,
							         observed.tx_fill, observed.rx_overflowed,
							         observed.tx_irq_enabled);
						end
					end
				end
			end
			// request side
			if (start && !busy) begin
				predict_status(op, data_byte, line_error, transmitter_empty, predicted);
				expected_status.push_back(predicted);
			end
			pending <= expected_status.size();
			fail_count <= fail_total;
		end
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the UART byte queue testbench: clock, reset, request stimulus and verdict.
// Depends on urb_pkg, uart_rx_tx_ring_buffers and urb_checker.

module tb_top;
	import urb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	logic                 clk               = 1'b0;
	logic                 arst_n            = 1'b0;
	logic                 start             = 1'b0;
	op_t                  op                = OP_RX_BYTE;
	byte_t                data_byte         = '0;
	logic                 line_error        = 1'b0;
	logic                 transmitter_empty = 1'b0;
	logic                 busy;
	logic                 done;
	logic                 send_valid;
	byte_t                send_byte;
	logic                 read_valid;
	byte_t                read_byte;
	logic                 put_rejected;
	logic [RX_FILL_W-1:0] rx_fill;
	logic [TX_FILL_W-1:0] tx_fill;
	logic                 rx_overflowed;
	logic                 tx_irq_enabled;
	int                   fail_count;
	int                   pending;

	int stalled_cycles = 0;
	bit idle_ok        = 1'b1;
	int good_rx        = 0;
	int puts           = 0;

	always #5 clk = ~clk;

	uart_rx_tx_ring_buffers i_dut (.*);

	urb_checker i_checker (.*);

	// Watchdog: cycles with neither a request taken nor a result out
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	// Present one request and hold it until taken; called just after an edge.
	// Each cycle before it idles with a chance of about one in eight.
	task automatic send_request(op_t o, byte_t d, logic e, logic t);
		if (idle_ok) begin
			while ($urandom_range(99) < 12) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		op <= o;
		data_byte <= d;
		line_error <= e;
		transmitter_empty <= t;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Random request; weights in percent for rx_byte, tx_empty and transmit writes,
	// the remainder goes to get_char
	task automatic send_weighted(int w_rx, int w_txe, int w_put);
		int    r;
		logic  e;
		byte_t d;
		r = $urandom_range(99);
		d = byte_t'($urandom);
		if (r < w_rx) begin
			e = ($urandom_range(99) < 8);
			if (!e)
				good_rx++;
			send_request(OP_RX_BYTE, d, e, 1'($urandom));
		end else if (r < w_rx + w_txe) begin
			send_request(OP_TX_EMPTY, d, 1'($urandom), 1'($urandom));
		end else if (r < w_rx + w_txe + w_put) begin
			puts++;
			send_request(OP_TX_WRITE, d, 1'($urandom), 1'($urandom));
		end else begin
			send_request(OP_GET_CHAR, d, 1'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty cases, straight send, queued sends, dropped byte
		send_request(OP_GET_CHAR, 8'h00, 1'b0, 1'b0);
		send_request(OP_TX_EMPTY, 8'hFF, 1'b1, 1'b1);
		send_request(OP_TX_WRITE, 8'hFF, 1'b0, 1'b1);
		send_request(OP_TX_WRITE, 8'h00, 1'b0, 1'b0);
		send_request(OP_TX_WRITE, 8'hA5, 1'b1, 1'b1);
		send_request(OP_TX_EMPTY, 8'h00, 1'b0, 1'b0);
		send_request(OP_TX_EMPTY, 8'h00, 1'b0, 1'b0);
		send_request(OP_TX_EMPTY, 8'h00, 1'b0, 1'b0);
		send_request(OP_RX_BYTE, 8'h00, 1'b0, 1'b0);
		send_request(OP_RX_BYTE, 8'hFF, 1'b0, 1'b1);
		send_request(OP_RX_BYTE, 8'h5A, 1'b1, 1'b0);
		send_request(OP_GET_CHAR, 8'hFF, 1'b1, 1'b1);
		send_request(OP_GET_CHAR, 8'h00, 1'b0, 1'b0);
		send_request(OP_GET_CHAR, 8'h00, 1'b0, 1'b0);
		send_request(OP_TX_WRITE, 8'hFF, 1'b0, 1'b0);
		send_request(OP_TX_EMPTY, 8'hFF, 1'b0, 1'b0);
		send_request(OP_TX_EMPTY, 8'h00, 1'b0, 1'b1);

		// Fill the receive queue past its depth to force the wrap
		good_rx = 0;
		while (good_rx < 260)
			send_weighted(90, 5, 5);

		// Fill the transmit queue until puts are refused; no idling here
		idle_ok = 1'b0;
		puts = 0;
		while (puts < 262)
			send_weighted(10, 0, 80);
		idle_ok = 1'b1;

		// Drain part of both queues, then a balanced mix
		repeat (60)
			send_weighted(5, 45, 5);
		repeat (40)
			send_weighted(25, 25, 25);
		start <= 1'b0;

		// Let the last results out, then a short settling time
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/urb_pkg.sv
hw/rtl/urb_front.sv
hw/rtl/urb_back.sv
hw/rtl/uart_rx_tx_ring_buffers.sv
sim/urb_checker.sv
sim/tb_top.sv
